// ===== hdl/bli_pkg.sv =====
`timescale 1ns / 1ps

package bli_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int REQ_W   = 3;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_FRONT = 3'd0,
    REQ_ADD_REAR  = 3'd1,
    REQ_DEL_FRONT = 3'd2,
    REQ_DEL_REAR  = 3'd3,
    REQ_DEL_AT    = 3'd4,
    REQ_INS_AT    = 3'd5
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INS,
    ACT_DEL
  } act_t;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_NEXT,
    RD_PREV
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_TAKE_RD,
    S_TAKE_CAP,
    S_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_INS_RD,
    S_INS_WR,
    S_PUT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    load;
    logic    setup;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap;
    logic    wr_shift;
    logic    put;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    act_t dec_act;
    act_t act;
    logic more_ins;
    logic more_del;
  } sts_t;

endpackage

// ===== hdl/bli_dp.sv =====
`timescale 1ns / 1ps

module bli_dp import bli_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [POS_W-1:0]   in_position,
  input  logic [VAL_W-1:0]   in_value,
  output logic [VAL_W-1:0]   out_removed_value,
  output logic [STAT_W-1:0]  out_status,
  output logic [TOTAL_W-1:0] out_element_total,
  output logic               out_is_empty
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [REQ_W-1:0]      req_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [AW-1:0]         idx_r;
  logic [AW-1:0]         cur_r;
  act_t                  act_r;
  stat_t                 stat_r;
  logic [DATA_WIDTH-1:0] removed_r;
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [DATA_WIDTH-1:0] list_mem [DEPTH];

  logic [VAL_W-1:0]   out_removed_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_empty_r;

  // request decode
  act_t          dec_act;
  stat_t         dec_stat;
  logic [AW-1:0] dec_idx;
  logic [CMPW-1:0] pos_e;
  logic [CMPW-1:0] cnt_e;
  logic          full;
  logic          empty;

  assign pos_e = CMPW'(pos_r);
  assign cnt_e = CMPW'(count_r);
  assign full  = (count_r >= CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    dec_act  = ACT_NONE;
    dec_stat = ST_OK;
    dec_idx  = '0;
    unique case (req_r)
      REQ_ADD_FRONT: begin
        if (full) dec_stat = ST_FULL;
        else dec_act = ACT_INS;
      end
      REQ_ADD_REAR: begin
        dec_idx = AW'(count_r);
        if (full) dec_stat = ST_FULL;
        else dec_act = ACT_INS;
      end
      REQ_DEL_FRONT: begin
        if (empty) dec_stat = ST_UNDER;
        else dec_act = ACT_DEL;
      end
      REQ_DEL_REAR: begin
        dec_idx = AW'(count_r - 1'b1);
        if (empty) dec_stat = ST_UNDER;
        else dec_act = ACT_DEL;
      end
      REQ_DEL_AT: begin
        dec_idx = AW'(pos_e - 1'b1);
        if (pos_e == '0 || pos_e > cnt_e) dec_stat = ST_RANGE;
        else dec_act = ACT_DEL;
      end
      REQ_INS_AT: begin
        dec_idx = AW'(pos_e - 1'b1);
        if (pos_e == '0 || pos_e > cnt_e + 1'b1) dec_stat = ST_RANGE;
        else if (full) dec_stat = ST_FULL;
        else dec_act = ACT_INS;
      end
      default: ;
    endcase
  end

  assign sts.dec_act  = dec_act;
  assign sts.act      = act_r;
  assign sts.more_ins = (cur_r > idx_r);
  assign sts.more_del = ((CW + 1)'(cur_r) + 1'b1 < (CW + 1)'(count_r));

  // memory ports
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  wr_en;

  always_comb begin
    case (cmd.rd_sel)
      RD_NEXT: rd_addr = cur_r + 1'b1;
      RD_PREV: rd_addr = cur_r - 1'b1;
      default: rd_addr = cur_r;
    endcase
  end

  assign wr_en   = cmd.wr_shift | cmd.put;
  assign wr_addr = cmd.put ? idx_r : cur_r;
  assign wr_data = cmd.put ? val_r : rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) list_mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rdata_r <= list_mem[rd_addr];
  end

  always_comb begin
    case (act_r)
      ACT_INS: count_nxt = count_r + 1'b1;
      ACT_DEL: count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      act_r   <= ACT_NONE;
    end else begin
      if (cmd.setup) act_r <= dec_act;
      if (cmd.finish) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      pos_r <= in_position;
      val_r <= DATA_WIDTH'(in_value);
    end
    if (cmd.setup) begin
      idx_r     <= dec_idx;
      cur_r     <= (dec_act == ACT_INS) ? AW'(count_r) : dec_idx;
      stat_r    <= dec_stat;
      removed_r <= '0;
    end else if (cmd.wr_shift) begin
      cur_r <= (act_r == ACT_DEL) ? cur_r + 1'b1 : cur_r - 1'b1;
    end
    if (cmd.cap) removed_r <= rdata_r;
    if (cmd.finish) begin
      out_removed_r <= VAL_W'(removed_r);
      out_status_r  <= stat_r;
      out_total_r   <= TOTAL_W'(count_nxt);
      out_empty_r   <= (count_nxt == '0);
    end
  end

  assign out_removed_value = out_removed_r;
  assign out_status        = out_status_r;
  assign out_element_total = out_total_r;
  assign out_is_empty      = out_empty_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above depth");
  a_del_drops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && act_r == ACT_DEL |=> count_r == CW'($past(count_r) - 1'b1))
    else $error("delete did not drop the count");
  a_put_ins: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put |-> act_r == ACT_INS && !sts.more_ins)
    else $error("element written before shift finished");
`endif

endmodule

// ===== hdl/bli_ctrl.sv =====
`timescale 1ns / 1ps

module bli_ctrl import bli_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DECIDE;
      S_DECIDE: begin
        unique case (sts.dec_act)
          ACT_INS: state_nxt = S_CHK;
          ACT_DEL: state_nxt = S_TAKE_RD;
          default: state_nxt = S_FINISH;
        endcase
      end
      S_TAKE_RD:  state_nxt = S_TAKE_CAP;
      S_TAKE_CAP: state_nxt = S_CHK;
      S_CHK: begin
        if (sts.act == ACT_DEL) state_nxt = sts.more_del ? S_DEL_RD : S_FINISH;
        else state_nxt = sts.more_ins ? S_INS_RD : S_PUT;
      end
      S_DEL_RD:   state_nxt = S_DEL_WR;
      S_DEL_WR:   state_nxt = S_CHK;
      S_INS_RD:   state_nxt = S_INS_WR;
      S_INS_WR:   state_nxt = S_CHK;
      S_PUT:      state_nxt = S_FINISH;
      S_FINISH:   if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = RD_CUR;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECIDE:   cmd.setup = 1'b1;
      S_TAKE_RD:  cmd.rd_en = 1'b1;
      S_TAKE_CAP: cmd.cap = 1'b1;
      S_DEL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_NEXT;
      end
      S_INS_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PREV;
      end
      S_DEL_WR, S_INS_WR: cmd.wr_shift = 1'b1;
      S_PUT:      cmd.put = 1'b1;
      S_FINISH:   cmd.finish = out_free;
      default: ;
    endcase
  end

  assign out_valid_nxt = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_valid_r || out_ready)
    else $error("result overwritten before taken");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("pending result dropped");
  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DECIDE)
    else $error("accepted beat not decoded");
`endif

endmodule

// ===== hdl/bounded_list_indexed_insert_delete_core.sv =====
`timescale 1ns / 1ps
// A rejected or unknown request goes from decode straight to the result; a delete at
// zero-based index i of n elements captures the removed element, then shifts the n-1-i
// later elements down, and an insert at i shifts the n-i elements from i up, then writes
// the new one; each shifted element costs a read, a write and a check on the list memory.
// One request is in work at a time; a new beat is taken from the cycle after the result load.
// Reset (rst_n, synchronous, active low) empties the list and drops any pending result.

module bounded_list_indexed_insert_delete_core import bli_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [POS_W-1:0]   in_position,
  input  logic [VAL_W-1:0]   in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VAL_W-1:0]   out_removed_value,
  output logic [STAT_W-1:0]  out_status,
  output logic [TOTAL_W-1:0] out_element_total,
  output logic               out_is_empty
);

  // Command and status between the sequencer and the list datapath.
  cmd_t cmd;
  sts_t sts;

  // Sequencer: takes a beat in idle, routes an accepted request through the shift loop of the
  // list memory and loads the result register once the output side is free.
  // A new beat may be taken while the previous result still waits there.
  bli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: request decode and status, element count, the list memory
  // (front at address 0) with its moving cursor, and the result register.
  // Deletes shift the tail down one entry at a time from the hole; inserts
  // shift from the rear up to the target slot, then write the new element.
  bli_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_removed_value (out_removed_value),
    .out_status        (out_status),
    .out_element_total (out_element_total),
    .out_is_empty      (out_is_empty)
  );

endmodule
